// ----- sv/nearest_centroid_search_top_macros.svh -----
// Assertion macros for the nearest centroid search block.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef NEAREST_CENTROID_SEARCH_TOP_MACROS_SVH
`define NEAREST_CENTROID_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NCS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ncs_pkg.sv -----
// Shared constants and types for the nearest centroid search block.
// No dependencies; used by every module of the block.
package ncs_pkg;

  // Default sizes, handed down from the top level parameters.
  localparam int DEF_MAX_CENTROIDS = 16;
  localparam int DEF_MAX_DIMS      = 16;
  localparam int DEF_COORD_WIDTH   = 16;

  // Distance results are saturated to this many bits.
  localparam int DIST_W = 36;

  // Configuration port.
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W_MIN    = 5;
  localparam int NUM_RESET         = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTROIDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS      = 2'd1;

  // Input commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Depth of the result queue; a power of two.
  localparam int Q_DEPTH = 4;

  // Control part of a token moving along the cell chain.
  typedef struct packed {
    logic vld;
    logic query;
    logic last;
  } ncs_ctl_t;

endpackage

// ----- sv/ncs_cell.sv -----
// One centroid cell: coordinate memory, distance pipeline, accumulator and
// one link of the running minimum. Depends on ncs_pkg.
module ncs_cell #(
  parameter int CELL_IDX      = 0,
  parameter int MAX_CENTROIDS = ncs_pkg::DEF_MAX_CENTROIDS,
  parameter int MAX_DIMS      = ncs_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH   = ncs_pkg::DEF_COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    clear_i,
  input  logic [$clog2(MAX_CENTROIDS+1)-1:0]      nc_i,
  input  ncs_pkg::ncs_ctl_t                       ctl_i,
  input  logic [$clog2(MAX_CENTROIDS)-1:0]        cidx_i,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] didx_i,
  input  logic signed [COORD_WIDTH-1:0]           coord_i,
  input  logic [$clog2(MAX_CENTROIDS)-1:0]        best_idx_i,
  input  logic [ncs_pkg::DIST_W-1:0]              best_dist_i,
  output ncs_pkg::ncs_ctl_t                       ctl_o,
  output logic [$clog2(MAX_CENTROIDS)-1:0]        cidx_o,
  output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] didx_o,
  output logic signed [COORD_WIDTH-1:0]           coord_o,
  output logic [$clog2(MAX_CENTROIDS)-1:0]        best_idx_o,
  output logic [ncs_pkg::DIST_W-1:0]              best_dist_o,
  output logic                                    res_vld_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int CI_W  = $clog2(MAX_CENTROIDS);
  localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NC_W  = $clog2(MAX_CENTROIDS+1);
  localparam int DW    = ncs_pkg::DIST_W;
  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = ((SQ_W > DW) ? SQ_W : DW) + 1;
  localparam bit FIRST = (CELL_IDX == 0);

  localparam logic [DW-1:0]   DIST_MAX = {DW{1'b1}};
  localparam logic [CI_W-1:0] MY_IDX   = CI_W'(CELL_IDX);

  // Coordinates of this centroid, one entry per dimension.
  logic signed [CW-1:0] mem [MAX_DIMS];

  ncs_pkg::ncs_ctl_t    ctl_r;
  logic [CI_W-1:0]      cidx_r;
  logic [DI_W-1:0]      didx_r;
  logic signed [CW-1:0] coord_r;

  logic                 s1_vld_r, s1_last_r;
  logic signed [CW-1:0] s1_x_r, s1_rd_r;
  logic                 s2_vld_r, s2_last_r;
  logic [CW-1:0]        s2_mag_r;
  logic                 s3_vld_r, s3_last_r;
  logic [SQ_W-1:0]      s3_sq_r;

  logic [DW-1:0]        acc_r, acc_nxt;
  logic [CI_W-1:0]      best_idx_r, best_idx_nxt;
  logic [DW-1:0]        best_dist_r, best_dist_nxt;
  logic                 res_vld_r;

  logic                 wr_en, rd_en;
  logic signed [CW:0]   diff;
  logic [CW-1:0]        mag;
  logic [SQ_W-1:0]      sq;
  logic [SUM_W-1:0]     sum;
  logic [DW-1:0]        sum_sat;
  logic                 take;

  assign wr_en = ctl_i.vld && (ctl_i.query == ncs_pkg::CMD_LOAD) && (cidx_i == MY_IDX)
                 && (32'(didx_i) < 32'(MAX_DIMS));
  assign rd_en = ctl_i.vld && (ctl_i.query == ncs_pkg::CMD_QUERY);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[didx_i] <= coord_i;
    end
    if (rd_en) begin
      s1_rd_r <= mem[didx_i];
    end
  end

  // Token forwarding and the distance pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      ctl_r    <= ctl_i;
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    cidx_r    <= cidx_i;
    didx_r    <= didx_i;
    coord_r   <= coord_i;
    s1_last_r <= ctl_i.last;
    s1_x_r    <= coord_i;
    s2_last_r <= s1_last_r;
    s2_mag_r  <= mag;
    s3_last_r <= s2_last_r;
    s3_sq_r   <= sq;
  end

  always_comb begin
    diff = (CW+1)'(s1_x_r) - (CW+1)'(s1_rd_r);
    mag  = diff[CW] ? CW'(-diff) : CW'(diff);
  end

  assign sq = SQ_W'(s2_mag_r) * SQ_W'(s2_mag_r);

  always_comb begin
    sum     = SUM_W'(acc_r) + SUM_W'(s3_sq_r);
    sum_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DW-1:0];
    take    = FIRST || ((NC_W'(CELL_IDX) < nc_i) && (sum_sat < best_dist_i));

    acc_nxt = acc_r;
    if (clear_i) begin
      acc_nxt = '0;
    end else if (s3_vld_r) begin
      acc_nxt = s3_last_r ? '0 : sum_sat;
    end

    best_idx_nxt  = take ? MY_IDX  : best_idx_i;
    best_dist_nxt = take ? sum_sat : best_dist_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      res_vld_r <= s3_vld_r && s3_last_r;
    end
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
  end

  assign ctl_o       = ctl_r;
  assign cidx_o      = cidx_r;
  assign didx_o      = didx_r;
  assign coord_o     = coord_r;
  assign best_idx_o  = best_idx_r;
  assign best_dist_o = best_dist_r;
  assign res_vld_o   = res_vld_r;

endmodule

// ----- sv/ncs_queue.sv -----
// Small result queue in flip-flops between the cell chain and the result port.
// Depends on ncs_pkg.
module ncs_queue #(
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_vld_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [ncs_pkg::DIST_W-1:0]  wr_dist_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IDX_W-1:0]            out_idx_o,
  output logic [ncs_pkg::DIST_W-1:0]  out_dist_o
);

  localparam int DEPTH = ncs_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [IDX_W-1:0]           idx_q  [DEPTH];
  logic [ncs_pkg::DIST_W-1:0] dist_q [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       pop;

  assign pop = out_valid_o && !out_stall_i;

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_vld_i && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!wr_vld_i && pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_vld_i) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
    if (wr_vld_i) begin
      idx_q[wr_ptr_r]  <= wr_idx_i;
      dist_q[wr_ptr_r] <= wr_dist_i;
    end
  end

  assign out_valid_o = (cnt_r != '0);
  assign out_idx_o   = idx_q[rd_ptr_r];
  assign out_dist_o  = dist_q[rd_ptr_r];

endmodule

// ----- sv/nearest_centroid_search_top.sv -----
// Top level of the nearest centroid search: configuration, query sequencing,
// the chain of centroid cells and the result queue. Depends on ncs_pkg,
// ncs_cell, ncs_queue and nearest_centroid_search_top_macros.svh.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------------
//  in       in_valid / in_stall    command, centroid_index, dim_index, coord_value
//  out      out_valid / out_stall  nearest_index, nearest_distance_sq
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_stall is low, loads and
// query coordinates alike. A result shows on out_valid once the last
// coordinate of its query has passed along the chain one cell per cycle,
// through the read, difference, square and accumulate stages of the last
// cell and through the result queue.
// The input stalls while four results are held or in flight (the result queue
// depth). Reset is synchronous and active low; the centroid memories are not
// cleared. Configuration writes are always accepted; those to a real register
// clear the partial query.
`include "nearest_centroid_search_top_macros.svh"

module nearest_centroid_search_top #(
  parameter int MAX_CENTROIDS = ncs_pkg::DEF_MAX_CENTROIDS,
  parameter int MAX_DIMS      = ncs_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH   = ncs_pkg::DEF_COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input channel.
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_command,
  input  logic [$clog2(MAX_CENTROIDS)-1:0]        in_centroid_index,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] in_dim_index,
  input  logic signed [COORD_WIDTH-1:0]           in_coord_value,
  // Result channel.
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [$clog2(MAX_CENTROIDS)-1:0]        out_nearest_index,
  output logic [ncs_pkg::DIST_W-1:0]              out_nearest_distance_sq,
  // Configuration channel.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [((((MAX_CENTROIDS > MAX_DIMS) ? $clog2(MAX_CENTROIDS+1)
                 : $clog2(MAX_DIMS+1)) > ncs_pkg::CFG_DATA_W_MIN)
                 ? ((MAX_CENTROIDS > MAX_DIMS) ? $clog2(MAX_CENTROIDS+1)
                 : $clog2(MAX_DIMS+1)) : ncs_pkg::CFG_DATA_W_MIN)-1:0] cfg_data
);

  localparam int CI_W     = $clog2(MAX_CENTROIDS);
  localparam int DI_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NC_W     = $clog2(MAX_CENTROIDS+1);
  localparam int ND_W     = $clog2(MAX_DIMS+1);
  localparam int CFG_NEED = (NC_W > ND_W) ? NC_W : ND_W;
  localparam int CFG_W    = (CFG_NEED > ncs_pkg::CFG_DATA_W_MIN) ? CFG_NEED
                            : ncs_pkg::CFG_DATA_W_MIN;
  localparam int RES_W    = $clog2(ncs_pkg::Q_DEPTH+1);
  localparam int LAT      = MAX_CENTROIDS + 3;
  localparam int DW       = ncs_pkg::DIST_W;

  // Configuration registers, kept as written and clamped on use.
  logic [CFG_W-1:0] nc_r, nd_r;
  logic [NC_W-1:0]  nc_eff;
  logic [ND_W-1:0]  nd_eff;
  logic             cfg_wr, cfg_hit;

  // Query sequencing and result credits.
  logic [ND_W-1:0]  qcnt_r, qcnt_nxt, qd, qd_next;
  logic             last_dim;
  logic [RES_W-1:0] reserved_r, reserved_nxt;
  logic             in_acc, reserve, out_acc;

  // Cell chain links; entry g feeds cell g.
  ncs_pkg::ncs_ctl_t    ctl_c   [MAX_CENTROIDS];
  logic [CI_W-1:0]      cidx_c  [MAX_CENTROIDS];
  logic [DI_W-1:0]      didx_c  [MAX_CENTROIDS];
  logic signed [COORD_WIDTH-1:0] coord_c [MAX_CENTROIDS];
  logic [CI_W-1:0]      bidx_c  [MAX_CENTROIDS];
  logic [DW-1:0]        bdist_c [MAX_CENTROIDS];

  logic                 res_vld;
  logic [CI_W-1:0]      res_idx;
  logic [DW-1:0]        res_dist;

  // The configuration port never back-pressures. Only writes that land on a
  // real register abort the partial query.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == ncs_pkg::REG_NUM_CENTROIDS) ||
                                (cfg_index == ncs_pkg::REG_NUM_DIMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= CFG_W'(ncs_pkg::NUM_RESET);
      nd_r <= CFG_W'(ncs_pkg::NUM_RESET);
    end else if (cfg_wr) begin
      case (cfg_index)
        ncs_pkg::REG_NUM_CENTROIDS: nc_r <= cfg_data;
        ncs_pkg::REG_NUM_DIMS:      nd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one, and a count above the maximum as the maximum.
  always_comb begin
    if (nc_r == '0) begin
      nc_eff = NC_W'(1);
    end else if (nc_r > CFG_W'(MAX_CENTROIDS)) begin
      nc_eff = NC_W'(MAX_CENTROIDS);
    end else begin
      nc_eff = NC_W'(nc_r);
    end
    if (nd_r == '0) begin
      nd_eff = ND_W'(1);
    end else if (nd_r > CFG_W'(MAX_DIMS)) begin
      nd_eff = ND_W'(MAX_DIMS);
    end else begin
      nd_eff = ND_W'(nd_r);
    end
  end

  // The input stalls during reset and whenever every queue slot is promised
  // to a result that is still in the chain or waiting at the output.
  assign in_stall = !rst_n || (reserved_r == RES_W'(ncs_pkg::Q_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Dimension of the current query coordinate, and whether it closes the query.
  always_comb begin
    qd       = (qcnt_r >= ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS - 1) : qcnt_r;
    qd_next  = qd + ND_W'(1);
    last_dim = (qd_next >= nd_eff);
    reserve  = in_acc && (in_command == ncs_pkg::CMD_QUERY) && last_dim;

    qcnt_nxt = qcnt_r;
    if (cfg_hit) begin
      qcnt_nxt = '0;
    end else if (in_acc && (in_command == ncs_pkg::CMD_QUERY)) begin
      qcnt_nxt = last_dim ? '0 : qd_next;
    end

    reserved_nxt = reserved_r + RES_W'(reserve) - RES_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r     <= '0;
      reserved_r <= '0;
    end else begin
      qcnt_r     <= qcnt_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  // The head of the chain sees the accepted transaction directly. For a query
  // the dimension field carries the running dimension count instead of the
  // port value, so every cell reads the right coordinate.
  always_comb begin
    ctl_c[0].vld   = in_acc;
    ctl_c[0].query = (in_command == ncs_pkg::CMD_QUERY);
    ctl_c[0].last  = (in_command == ncs_pkg::CMD_QUERY) && last_dim;
    cidx_c[0]      = in_centroid_index;
    didx_c[0]      = (in_command == ncs_pkg::CMD_QUERY) ? DI_W'(qd) : in_dim_index;
    coord_c[0]     = in_coord_value;
    bidx_c[0]      = '0;
    bdist_c[0]     = '0;
  end

  // Each cell passes the transaction to its neighbor in the next cycle and the
  // running minimum once its own accumulator is final, so the minimum from
  // cell g arrives at cell g+1 in exactly the cycle that cell needs it.
  for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
    if (g < MAX_CENTROIDS - 1) begin : g_mid
      ncs_cell #(
        .CELL_IDX      (g),
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .COORD_WIDTH   (COORD_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_i     (cfg_hit),
        .nc_i        (nc_eff),
        .ctl_i       (ctl_c[g]),
        .cidx_i      (cidx_c[g]),
        .didx_i      (didx_c[g]),
        .coord_i     (coord_c[g]),
        .best_idx_i  (bidx_c[g]),
        .best_dist_i (bdist_c[g]),
        .ctl_o       (ctl_c[g+1]),
        .cidx_o      (cidx_c[g+1]),
        .didx_o      (didx_c[g+1]),
        .coord_o     (coord_c[g+1]),
        .best_idx_o  (bidx_c[g+1]),
        .best_dist_o (bdist_c[g+1]),
        .res_vld_o   ()
      );
    end else begin : g_tail
      // The last cell forwards no transaction; its minimum is the result.
      ncs_cell #(
        .CELL_IDX      (g),
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_DIMS      (MAX_DIMS),
        .COORD_WIDTH   (COORD_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_i     (cfg_hit),
        .nc_i        (nc_eff),
        .ctl_i       (ctl_c[g]),
        .cidx_i      (cidx_c[g]),
        .didx_i      (didx_c[g]),
        .coord_i     (coord_c[g]),
        .best_idx_i  (bidx_c[g]),
        .best_dist_i (bdist_c[g]),
        .ctl_o       (),
        .cidx_o      (),
        .didx_o      (),
        .coord_o     (),
        .best_idx_o  (res_idx),
        .best_dist_o (res_dist),
        .res_vld_o   (res_vld)
      );
    end
  end

  // Results are buffered so the chain never has to stop.
  ncs_queue #(
    .IDX_W (CI_W)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_vld_i    (res_vld),
    .wr_idx_i    (res_idx),
    .wr_dist_i   (res_dist),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_idx_o   (out_nearest_index),
    .out_dist_o  (out_nearest_distance_sq)
  );

  // The credit count never goes past the queue depth.
  `NCS_ASSERT_IMPLIES(a_credit_bound, 1'b1, reserved_r <= RES_W'(ncs_pkg::Q_DEPTH), "result credits exceed queue depth")

  // A result waiting at the output always holds a credit.
  `NCS_ASSERT_IMPLIES(a_out_has_credit, out_valid, reserved_r != '0, "result shown without a credit")

  // Results leave the chain in step with the closing query coordinates that went in.
  `NCS_ASSERT_IMPLIES(a_result_timing, 1'b1, res_vld == $past(reserve, LAT), "chain result out of step with its query")

  // A register write restarts the dimension count.
  `NCS_ASSERT_NEXT(a_cfg_clears_query, cfg_hit, qcnt_r == '0, "dimension count not cleared by a register write")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for nearest_centroid_search_top: random and directed
// loads, query coordinates and register writes, checked against a predictor.
// Depends on ncs_pkg and the nearest_centroid_search_top RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCENT = ncs_pkg::DEF_MAX_CENTROIDS;
  localparam int NDIM  = ncs_pkg::DEF_MAX_DIMS;
  // A result reaches the output after its last coordinate crosses the chain;
  // loads travel the same chain, so this margin covers anything in flight.
  localparam int SETTLE       = 2 * NCENT + 8;
  // The directed part adds close to three hundred more items.
  localparam int RANDOM_ITEMS = 370;
  // The two spare register indexes decode to nothing.
  localparam logic [ncs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ncs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [ncs_pkg::DIST_W:0] DIST_SAT = {1'b0, {ncs_pkg::DIST_W{1'b1}}};

  // One entry of the stimulus queue: an input transaction, a register write,
  // or a pause in which the sender waits until every pending result is back.
  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic               cmd;
    logic [3:0]         cidx;
    logic [3:0]         didx;
    logic signed [15:0] coord;
    logic [1:0]         reg_idx;
    logic [4:0]         reg_val;
    int                 gap;
    bit                 calm;
  } stim_step_t;

  typedef struct {
    logic [3:0]                 idx;
    logic [ncs_pkg::DIST_W-1:0] dist_sq;
  } nearest_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = ncs_pkg::CMD_LOAD;
  logic [3:0]         in_centroid_index = '0;
  logic [3:0]         in_dim_index = '0;
  logic signed [15:0] in_coord_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_nearest_index;
  logic [ncs_pkg::DIST_W-1:0] out_nearest_distance_sq;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [4:0]         cfg_data = '0;

  nearest_centroid_search_top uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_centroid_index       (in_centroid_index),
    .in_dim_index            (in_dim_index),
    .in_coord_value          (in_coord_value),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_nearest_index       (out_nearest_index),
    .out_nearest_distance_sq (out_nearest_distance_sq),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  // Predictor state: the centroid table, one distance sum per centroid, the
  // count of query coordinates taken so far and the two registers.
  logic signed [15:0]       cent_tab [NCENT][NDIM];
  logic [ncs_pkg::DIST_W:0] dist_acc [NCENT];
  logic [4:0]               dims_done = '0;
  logic [4:0]               ncent_reg = 5'(ncs_pkg::NUM_RESET);
  logic [4:0]               ndim_reg = 5'(ncs_pkg::NUM_RESET);
  nearest_t                 nearest_q[$];

  // Bookkeeping for the summary and the verdict.
  int mismatches = 0;
  int results_checked = 0;
  int tied_results = 0;
  int loads_seen = 0;
  int coords_seen = 0;
  int cfg_writes = 0;
  int pauses_done = 0;

  // Stimulus queue, filled up front, and the state used while filling it.
  stim_step_t stim_q[$];
  bit         fill_calm = 1'b0;
  int         fill_nd = ncs_pkg::NUM_RESET;
  int         fill_open = 0;
  int         items_queued = 0;

  // Driver state. out_calm tells the result side to stop stalling while the
  // sender is in a stretch without gaps.
  stim_step_t cur;
  bit         have_cur = 1'b0;
  int         wait_cnt = 0;
  bit         out_calm = 1'b0;
  int         stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // A register value of zero acts as one, anything above the maximum as the
  // maximum.
  function automatic int clamp_reg(input logic [4:0] v, input int maxv);
    if (v == 0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  task automatic clear_partial();
    foreach (dist_acc[c]) dist_acc[c] = '0;
    dims_done = '0;
  endtask

  // Either real register write drops the query in progress; the spare
  // indexes change nothing.
  task automatic apply_cfg_write(input logic [1:0] idx, input logic [4:0] val);
    if (idx == ncs_pkg::REG_NUM_CENTROIDS) begin
      ncent_reg = val;
      clear_partial();
    end else if (idx == ncs_pkg::REG_NUM_DIMS) begin
      ndim_reg = val;
      clear_partial();
    end
    cfg_writes++;
  endtask

  // Applies one accepted input transaction. A load lands in the table at once,
  // even in the middle of a query. A query coordinate adds its squared
  // difference to every centroid's sum; after the last configured dimension
  // the nearest centroid (lowest index on a tie) becomes the expected result.
  task automatic predict_search(input logic cmd, input logic [3:0] ci,
                                input logic [3:0] di, input logic signed [15:0] x);
    longint                   diff;
    logic [ncs_pkg::DIST_W:0] sq;
    logic [ncs_pkg::DIST_W:0] sum;
    int                       row;
    int                       nc;
    int                       best;
    bit                       tie;
    nearest_t                 res;
    if (cmd == ncs_pkg::CMD_LOAD) begin
      cent_tab[ci][di] = x;
      loads_seen++;
    end else begin
      coords_seen++;
      row = (dims_done >= NDIM) ? NDIM - 1 : int'(dims_done);
      for (int c = 0; c < NCENT; c++) begin
        diff = longint'(x) - longint'(cent_tab[c][row]);
        sq = (ncs_pkg::DIST_W+1)'(diff * diff);
        sum = dist_acc[c] + sq;
        dist_acc[c] = (sum > DIST_SAT) ? DIST_SAT : sum;
      end
      dims_done = 5'(row + 1);
      if (dims_done >= clamp_reg(ndim_reg, NDIM)) begin
        nc = clamp_reg(ncent_reg, NCENT);
        best = 0;
        tie = 1'b0;
        for (int c = 1; c < nc; c++) begin
          if (dist_acc[c] < dist_acc[best]) best = c;
        end
        for (int c = 0; c < nc; c++) begin
          if (c != best && dist_acc[c] == dist_acc[best]) tie = 1'b1;
        end
        if (tie) tied_results++;
        res.idx = 4'(best);
        res.dist_sq = dist_acc[best][ncs_pkg::DIST_W-1:0];
        nearest_q.push_back(res);
        clear_partial();
      end
    end
  endtask

  // Helpers that build the stimulus queue.
  function automatic int draw_gap();
    return fill_calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Extremes, values close to zero (so that near ties occur) and full range.
  function automatic logic signed [15:0] draw_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3, 4: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Register values: out of range on both sides, the legal extremes, and
  // mostly short settings so that results come often.
  function automatic logic [4:0] draw_count();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      4, 5: return 5'($urandom_range(2, 4));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic stim_step_t make_step(input step_kind_t k, input int gap);
    stim_step_t s;
    s.kind = k;
    s.cmd = ncs_pkg::CMD_LOAD;
    s.cidx = '0;
    s.didx = '0;
    s.coord = '0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.gap = gap;
    s.calm = fill_calm;
    return s;
  endfunction

  task automatic push_load(input logic [3:0] ci, input logic [3:0] di,
                           input logic signed [15:0] v);
    stim_step_t s;
    s = make_step(STEP_ITEM, draw_gap());
    s.cidx = ci;
    s.didx = di;
    s.coord = v;
    stim_q.push_back(s);
    items_queued++;
  endtask

  // The index fields are unused on a query but still get random bits.
  task automatic push_coord(input logic signed [15:0] v);
    stim_step_t s;
    s = make_step(STEP_ITEM, draw_gap());
    s.cmd = ncs_pkg::CMD_QUERY;
    s.cidx = 4'($urandom);
    s.didx = 4'($urandom);
    s.coord = v;
    stim_q.push_back(s);
    items_queued++;
    fill_open++;
    if (fill_open >= fill_nd) fill_open = 0;
  endtask

  // The driver holds a register write back until the block is quiet.
  task automatic push_cfg(input logic [1:0] idx, input logic [4:0] val);
    stim_step_t s;
    s = make_step(STEP_CFG, SETTLE);
    s.reg_idx = idx;
    s.reg_val = val;
    stim_q.push_back(s);
    if (idx == ncs_pkg::REG_NUM_DIMS) fill_nd = clamp_reg(val, NDIM);
    if (idx == ncs_pkg::REG_NUM_CENTROIDS || idx == ncs_pkg::REG_NUM_DIMS) fill_open = 0;
  endtask

  task automatic push_drain();
    stim_q.push_back(make_step(STEP_DRAIN, 0));
  endtask

  // Reset is held at the start and never again.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver. Each edge first retires the transactions that completed there and
  // feeds them to the predictor, then, if both channels are free, works on the
  // next queued step: an input transaction waits out its drawn gap, while a
  // register write or a pause first waits for every pending result (and a
  // write then also waits out its SETTLE gap). valid and the payload get a
  // single nonblocking assignment per edge, so back-to-back transactions keep
  // valid high without a glitch.
  always @(posedge clk) begin : drive_proc
    logic in_next;
    logic cfg_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      have_cur = 1'b0;
      ncent_reg = 5'(ncs_pkg::NUM_RESET);
      ndim_reg = 5'(ncs_pkg::NUM_RESET);
      clear_partial();
    end else begin
      in_next = in_valid && in_stall;
      cfg_next = cfg_valid && !cfg_ready;
      if (in_valid && !in_stall) begin
        predict_search(in_command, in_centroid_index, in_dim_index, in_coord_value);
      end
      if (cfg_valid && cfg_ready) apply_cfg_write(cfg_index, cfg_data);
      if (!in_next && !cfg_next) begin
        if (!have_cur && stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          have_cur = 1'b1;
          wait_cnt = cur.gap;
        end
        if (have_cur) begin
          if (cur.kind != STEP_ITEM && nearest_q.size() != 0) begin
            wait_cnt = cur.gap;
          end else if (wait_cnt > 0) begin
            wait_cnt--;
          end else begin
            case (cur.kind)
              STEP_ITEM: begin
                in_command <= cur.cmd;
                in_centroid_index <= cur.cidx;
                in_dim_index <= cur.didx;
                in_coord_value <= cur.coord;
                in_next = 1'b1;
                out_calm = cur.calm;
              end
              STEP_CFG: begin
                cfg_index <= cur.reg_idx;
                cfg_data <= cur.reg_val;
                cfg_next = 1'b1;
              end
              default: begin
                pauses_done++;
              end
            endcase
            have_cur = 1'b0;
          end
        end
      end
      in_valid <= in_next;
      cfg_valid <= cfg_next;
    end
  end

  // Monitor. Every accepted result is compared with the oldest expectation;
  // after each one the receiver draws a random stall, except while the sender
  // runs without gaps.
  always @(posedge clk) begin : result_check
    nearest_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (nearest_q.size() == 0) begin
          report_mismatch($sformatf("result index %0d distance %0d with nothing pending",
                                    out_nearest_index, out_nearest_distance_sq));
        end else begin
          want = nearest_q.pop_front();
          if (out_nearest_index !== want.idx) begin
            report_mismatch($sformatf("nearest_index got %0d expected %0d",
                                      out_nearest_index, want.idx));
          end
          if (out_nearest_distance_sq !== want.dist_sq) begin
            report_mismatch($sformatf("nearest_distance_sq got %0d expected %0d",
                                      out_nearest_distance_sq, want.dist_sq));
          end
        end
        stall_left = out_calm ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int base;
    int phase_len;
    int pick;
    int a;
    int b;
    logic signed [15:0] v;

    // Both registers at their legal maximum, then every table entry written,
    // since a query reads all centroids at each queried dimension. Centroid 0
    // sits at the negative corner and centroid 1 at the positive corner.
    fill_calm = 1'b1;
    push_cfg(ncs_pkg::REG_NUM_CENTROIDS, 5'd16);
    push_cfg(ncs_pkg::REG_NUM_DIMS, 5'd16);
    for (int c = 0; c < NCENT; c++) begin
      for (int d = 0; d < NDIM; d++) begin
        if (c == 0) v = 16'sh8000;
        else if (c == 1) v = 16'sh7FFF;
        else v = draw_coord();
        push_load(4'(c), 4'(d), v);
      end
    end

    // Zero centroids acts as one and 31 dimensions as sixteen: the query at
    // the positive corner against centroid 0 gives the largest distance.
    push_cfg(ncs_pkg::REG_NUM_CENTROIDS, 5'd0);
    push_cfg(ncs_pkg::REG_NUM_DIMS, 5'd31);
    repeat (NDIM) push_coord(16'sh7FFF);

    // Seventeen centroids acts as sixteen; one dimension; both corners.
    push_cfg(ncs_pkg::REG_NUM_CENTROIDS, 5'd17);
    push_cfg(ncs_pkg::REG_NUM_DIMS, 5'd1);
    push_coord(16'sh8000);
    push_coord(16'sh7FFF);

    // Two centroids at the same spot: the lower index has to win the tie.
    push_load(4'd2, 4'd0, 16'sd5);
    push_load(4'd4, 4'd0, 16'sd5);
    push_coord(16'sd5);

    // A load in the middle of a query changes a dimension not yet reached.
    fill_calm = 1'b0;
    push_cfg(ncs_pkg::REG_NUM_DIMS, 5'd3);
    push_coord(draw_coord());
    push_coord(draw_coord());
    push_load(4'd3, 4'd2, draw_coord());
    push_coord(draw_coord());

    // A register write drops a half-done query without a result.
    push_coord(draw_coord());
    push_drain();
    push_cfg(ncs_pkg::REG_NUM_DIMS, 5'd2);
    push_coord(draw_coord());
    push_coord(draw_coord());

    // The spare indexes, written only with no query open.
    push_cfg(REG_SPARE_A, 5'($urandom));
    push_cfg(REG_SPARE_B, 5'($urandom));

    // Random phases: a fresh register setting, then mostly query coordinates
    // with loads, tie-making centroid copies and sender pauses mixed in. A
    // phase may end inside a query, which the next write then drops.
    base = items_queued;
    while (items_queued < base + RANDOM_ITEMS) begin
      fill_calm = ($urandom_range(0, 4) == 0);
      if (fill_open == 0 && $urandom_range(0, 5) == 0) begin
        push_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 5'($urandom));
      end
      case ($urandom_range(0, 2))
        0: push_cfg(ncs_pkg::REG_NUM_CENTROIDS, draw_count());
        1: push_cfg(ncs_pkg::REG_NUM_DIMS, draw_count());
        default: begin
          push_cfg(ncs_pkg::REG_NUM_DIMS, draw_count());
          push_cfg(ncs_pkg::REG_NUM_CENTROIDS, draw_count());
        end
      endcase
      phase_len = $urandom_range(10, 50);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_load(4'($urandom), 4'($urandom), draw_coord());
        end else if (pick < 17) begin
          a = $urandom_range(0, NCENT - 2);
          b = $urandom_range(a + 1, NCENT - 1);
          for (int d = 0; d < NDIM; d++) begin
            v = draw_coord();
            push_load(4'(a), 4'(d), v);
            push_load(4'(b), 4'(d), v);
          end
        end else if (pick < 19) begin
          push_drain();
        end else begin
          push_coord(draw_coord());
        end
      end
    end

    // Let everything drain, then a final quiet stretch to catch stray results.
    while (stim_q.size() != 0 || have_cur || in_valid || cfg_valid) @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d loads, %0d query coordinates, %0d register writes, %0d pauses.",
             loads_seen, coords_seen, cfg_writes, pauses_done);
    $display("Checked %0d nearest-centroid results, %0d of them settled by a tie.",
             results_checked, tied_results);
    if (mismatches == 0) begin
      $display("[nearest_centroid_search_top] OK");
    end else begin
      $display("[nearest_centroid_search_top] ERROR");
    end
    $finish;
  end

  // Watchdog against a hang; the slowest legal run ends long before its timeout.
  initial begin
    #2000000;
    $display("[nearest_centroid_search_top] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ncs_pkg.sv
sv/ncs_cell.sv
sv/ncs_queue.sv
sv/nearest_centroid_search_top.sv
dv/tb.sv
